// ===== rtl/bpg_pkg.sv =====
package bpg_pkg;

  localparam int TICK_WRAP          = 300;
  localparam int PHASE_STEPS        = 79;
  localparam int BEACON_PERIOD_DEF  = 50;
  localparam int PHASE_W            = 7;
  localparam int PHASE_DEPTH        = 1 << PHASE_W;

  // Q30 angle constants: 0.08 rad per phase step
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] ANG_STEP    = 64'd85899346;
  localparam logic [63:0] ANG_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] ANG_PI      = 64'd3373259426;
  localparam logic [63:0] ANG_HALF_PI = 64'd1686629713;

  typedef enum logic [3:0] {
    MODE_CRITICAL   = 4'd0,
    MODE_FAULT      = 4'd1,
    MODE_UPDATE     = 4'd2,
    MODE_BENCH      = 4'd3,
    MODE_PH         = 4'd4,
    MODE_HEAT_PULSE = 4'd5,
    MODE_HEAT_DC    = 4'd6,
    MODE_HEAT       = 4'd7,
    MODE_PULSE      = 4'd8,
    MODE_DC         = 4'd9,
    MODE_ENV        = 4'd10,
    MODE_CONNECTED  = 4'd11,
    MODE_BEACON     = 4'd12
  } mode_t;

  typedef struct packed {
    logic failsafe_latched;
    logic failsafe_critical;
    logic update_in_progress;
    logic thermocouple_seen;
    logic adc_connected;
    logic usb_console;
    logic ph_active;
    logic heating_active;
    logic supply_active;
    logic pulsed_mode;
    logic env_sensors_missing;
    logic clients_present;
  } flags_t;

  // One tick after the counters have advanced: flags, breathing phase and blink states
  typedef struct packed {
    flags_t              flags;
    logic [PHASE_W-1:0]  phase;
    logic                fast_on;
    logic                third_on;
    logic                fault_on;
    logic                beacon_on;
  } tick_item_t;

  typedef enum logic [2:0] {
    TAB_BENCH_R = 3'd0,
    TAB_BENCH_B = 3'd1,
    TAB_PH_R    = 3'd2,
    TAB_PH_B    = 3'd3,
    TAB_CONN_G  = 3'd4,
    TAB_CONN_B  = 3'd5
  } tab_sel_t;

  typedef logic [7:0] lvl_tab_t [PHASE_DEPTH];

  // Sine of n * 0.08 rad in signed Q30, Taylor series to x^15 on [0, pi/2]
  function automatic longint sine_q30(input int unsigned n);
    logic [63:0] r;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic        neg;
    r   = (64'(n) * ANG_STEP) % ANG_TWO_PI;
    neg = 1'b0;
    if (r >= ANG_PI) begin
      neg = 1'b1;
      r   = r - ANG_PI;
    end
    if (r > ANG_HALF_PI) begin
      r = ANG_PI - r;
    end
    x2   = (r * r) >> 30;
    term = r;
    sum  = longint'(r);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(Q30_ONE)) begin
      sum = longint'(Q30_ONE);
    end
    return neg ? -sum : sum;
  endfunction

  // floor((base + amp * s) / 2^shift), s in Q30, clamped to 0..255
  function automatic logic [7:0] level(input longint base, input longint amp,
                                       input int unsigned shift, input longint s);
    longint      num;
    logic [63:0] v;
    num = base * longint'(Q30_ONE) + amp * s;
    if (num < 0) begin
      num = 0;
    end
    v = 64'(num) >> (30 + shift);
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic lvl_tab_t make_tab(input tab_sel_t sel);
    lvl_tab_t tab;
    for (int i = 0; i < PHASE_DEPTH; i++) begin
      unique case (sel)
        TAB_BENCH_R: tab[i] = level(27, 18, 0, sine_q30(i));
        TAB_BENCH_B: tab[i] = level(45, 30, 0, sine_q30(i));
        TAB_PH_R:    tab[i] = level(189, 91, 2, sine_q30(2 * i));
        TAB_PH_B:    tab[i] = level(243, 117, 3, sine_q30(2 * i));
        TAB_CONN_G:  tab[i] = level(111, 9, 1, sine_q30(i));
        TAB_CONN_B:  tab[i] = level(111, 9, 3, sine_q30(i));
        default:     tab[i] = 8'd0;
      endcase
    end
    return tab;
  endfunction

  localparam lvl_tab_t BENCH_R_TAB = make_tab(TAB_BENCH_R);
  localparam lvl_tab_t BENCH_B_TAB = make_tab(TAB_BENCH_B);
  localparam lvl_tab_t PH_R_TAB    = make_tab(TAB_PH_R);
  localparam lvl_tab_t PH_B_TAB    = make_tab(TAB_PH_B);
  localparam lvl_tab_t CONN_G_TAB  = make_tab(TAB_CONN_G);
  localparam lvl_tab_t CONN_B_TAB  = make_tab(TAB_CONN_B);

endpackage

// ===== rtl/bpg_tick.sv =====
module bpg_tick #(
  parameter int BEACON_PERIOD = bpg_pkg::BEACON_PERIOD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpg_pkg::flags_t     flags,
  output logic                item_valid,
  output bpg_pkg::tick_item_t item,
  input  logic                item_take
);
  import bpg_pkg::*;

  localparam int BW = $clog2(BEACON_PERIOD);

  logic [8:0]         tick_count;
  logic [8:0]         tick_count_next;
  logic [8:0]         tick_inc;
  logic               tick_wrap;
  logic [2:0]         mod6;
  logic [2:0]         mod6_next;
  logic [4:0]         mod20;
  logic [4:0]         mod20_next;
  logic [BW-1:0]      modb;
  logic [BW-1:0]      modb_next;
  logic [PHASE_W-1:0] breath_phase;
  logic [PHASE_W-1:0] breath_phase_next;
  logic [PHASE_W:0]   phase_inc;
  logic               accept;

  assign in_stall = item_valid && !item_take;
  assign accept   = in_valid && !in_stall;

  // Side counters track tick_count mod 6, 20 and the beacon period
  always_comb begin
    tick_inc        = tick_count + 9'd1;
    tick_wrap       = tick_inc >= 9'(TICK_WRAP);
    tick_count_next = tick_wrap ? 9'd0 : tick_inc;
    mod6_next       = (tick_wrap || mod6 == 3'd5) ? 3'd0 : mod6 + 3'd1;
    mod20_next      = (tick_wrap || mod20 == 5'd19) ? 5'd0 : mod20 + 5'd1;
    modb_next       = (tick_wrap || modb == BW'(BEACON_PERIOD - 1)) ? '0 : modb + BW'(1);
    phase_inc       = {1'b0, breath_phase} + (PHASE_W + 1)'(1);
    breath_phase_next = (phase_inc >= (PHASE_W + 1)'(PHASE_STEPS)) ? '0
                                                                 : phase_inc[PHASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      mod6         <= '0;
      mod20        <= '0;
      modb         <= '0;
      breath_phase <= '0;
      item_valid   <= 1'b0;
    end else begin
      if (accept) begin
        tick_count   <= tick_count_next;
        mod6         <= mod6_next;
        mod20        <= mod20_next;
        modb         <= modb_next;
        breath_phase <= breath_phase_next;
        item_valid   <= 1'b1;
      end else if (item_take) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.flags     <= flags;
      item.phase     <= breath_phase_next;
      item.fast_on   <= !tick_count_next[1];
      item.third_on  <= mod6_next < 3'd3;
      item.fault_on  <= mod20_next < 5'd10;
      item.beacon_on <= modb_next < BW'(3);
    end
  end

endmodule

// ===== rtl/bpg_color.sv =====
module bpg_color (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  bpg_pkg::tick_item_t item,
  output logic                item_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [3:0]          mode_code
);
  import bpg_pkg::*;

  logic [7:0] r_next;
  logic [7:0] g_next;
  logic [7:0] b_next;
  mode_t      mode_next;
  flags_t     f;

  assign item_take = item_valid && (!out_valid || !out_stall);
  assign f         = item.flags;

  always_comb begin
    r_next    = 8'd0;
    g_next    = 8'd0;
    b_next    = 8'd0;
    mode_next = MODE_BEACON;
    priority if (f.failsafe_latched) begin
      if (f.failsafe_critical) begin
        mode_next = MODE_CRITICAL;
        r_next    = item.fast_on ? 8'd120 : 8'd0;
      end else begin
        mode_next = MODE_FAULT;
        r_next    = item.fault_on ? 8'd65 : 8'd0;
      end
    end else if (f.update_in_progress) begin
      mode_next = MODE_UPDATE;
      r_next    = item.fast_on ? 8'd75 : 8'd0;
      g_next    = r_next;
      b_next    = r_next;
    end else if (!f.thermocouple_seen && !f.adc_connected && f.usb_console) begin
      mode_next = MODE_BENCH;
      r_next    = BENCH_R_TAB[item.phase];
      b_next    = BENCH_B_TAB[item.phase];
    end else if (f.ph_active) begin
      mode_next = MODE_PH;
      r_next    = PH_R_TAB[item.phase];
      b_next    = PH_B_TAB[item.phase];
    end else if (f.heating_active && f.supply_active) begin
      if (f.pulsed_mode) begin
        mode_next = MODE_HEAT_PULSE;
        r_next    = item.third_on ? 8'd25 : 8'd0;
        g_next    = item.third_on ? 8'd80 : 8'd20;
        b_next    = item.third_on ? 8'd100 : 8'd60;
      end else begin
        mode_next = MODE_HEAT_DC;
        r_next    = 8'd15;
        g_next    = 8'd65;
        b_next    = 8'd85;
      end
    end else if (f.heating_active) begin
      mode_next = MODE_HEAT;
      g_next    = 8'd15;
      b_next    = 8'd90;
    end else if (f.supply_active) begin
      if (f.pulsed_mode) begin
        mode_next = MODE_PULSE;
        r_next    = item.third_on ? 8'd10 : 8'd0;
        g_next    = item.third_on ? 8'd55 : 8'd5;
        b_next    = item.third_on ? 8'd90 : 8'd15;
      end else begin
        mode_next = MODE_DC;
        g_next    = 8'd60;
        b_next    = 8'd80;
      end
    end else if (f.env_sensors_missing) begin
      mode_next = MODE_ENV;
      r_next    = 8'd45;
      g_next    = 8'd30;
    end else if (f.clients_present) begin
      mode_next = MODE_CONNECTED;
      g_next    = CONN_G_TAB[item.phase];
      b_next    = CONN_B_TAB[item.phase];
    end else begin
      mode_next = MODE_BEACON;
      g_next    = item.beacon_on ? 8'd65 : 8'd4;
      b_next    = item.beacon_on ? 8'd20 : 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      red       <= r_next;
      green     <= g_next;
      blue      <= b_next;
      mode_code <= mode_next;
    end
  end

endmodule

// ===== rtl/status_beacon_pattern_generator.sv =====
// Status beacon pattern generator: each input transaction is one display tick with
// twelve status flags; each one yields exactly one colour (red, green, blue) and a
// mode code chosen by fixed priority. Each accepted transaction passes two register
// stages before its result is offered: the first register stage advances
// the tick counter (mod 300), its mod 6 / mod 20 / mod BEACON_PERIOD side counters and
// the breathing phase, and the second looks the phase up in constant breathing tables
// and registers the colour. Throughput stays at one per cycle while out_stall is low; the
// counters advance only on accepted transactions, and reset returns them all to zero.
module status_beacon_pattern_generator #(
  parameter int BEACON_PERIOD = bpg_pkg::BEACON_PERIOD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       failsafe_latched,
  input  logic       failsafe_critical,
  input  logic       update_in_progress,
  input  logic       thermocouple_seen,
  input  logic       adc_connected,
  input  logic       usb_console,
  input  logic       ph_active,
  input  logic       heating_active,
  input  logic       supply_active,
  input  logic       pulsed_mode,
  input  logic       env_sensors_missing,
  input  logic       clients_present,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [3:0] mode_code
);
  import bpg_pkg::*;

  flags_t     flags;
  tick_item_t item;
  logic       item_valid;
  logic       item_take;

  always_comb begin
    flags.failsafe_latched    = failsafe_latched;
    flags.failsafe_critical   = failsafe_critical;
    flags.update_in_progress  = update_in_progress;
    flags.thermocouple_seen   = thermocouple_seen;
    flags.adc_connected       = adc_connected;
    flags.usb_console         = usb_console;
    flags.ph_active           = ph_active;
    flags.heating_active      = heating_active;
    flags.supply_active       = supply_active;
    flags.pulsed_mode         = pulsed_mode;
    flags.env_sensors_missing = env_sensors_missing;
    flags.clients_present     = clients_present;
  end

  bpg_tick #(
    .BEACON_PERIOD(BEACON_PERIOD)
  ) u_tick (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .flags     (flags),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take)
  );

  bpg_color u_color (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .mode_code (mode_code)
  );

endmodule

// ===== rtl/bpg_checker.sv =====
module bpg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [3:0] mode_code
);
  import bpg_pkg::*;

  // Output register empties on reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // Empty output register means the pipeline can always take a transaction
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // Critical strobe is red only, either full or off
  assert property (@(posedge clk) disable iff (rst)
      out_valid && mode_code == MODE_CRITICAL |->
      green == 8'd0 && blue == 8'd0 && (red == 8'd120 || red == 8'd0))
    else $error("critical strobe colour wrong");

  // Update blink is white
  assert property (@(posedge clk) disable iff (rst)
      out_valid && mode_code == MODE_UPDATE |-> red == green && green == blue)
    else $error("update blink not white");

endmodule

bind status_beacon_pattern_generator bpg_checker u_bpg_checker (.*);
